// File: hw/rtl/srdc_pkg.sv
`timescale 1ns / 1ps

package srdc_pkg;

    // Input beat
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  reg_offset;
        logic [15:0] data_word;
        logic [7:0]  scanline;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  commit_offset;
        logic [15:0] word_value;
        logic        last;
    } out_t;

    // Operation modes
    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_IMM   = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_SET   = 3'd3;
    localparam logic [2:0] MODE_CLR   = 3'd4;
    localparam logic [2:0] MODE_FLUSH = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_FIRST_LINE = 1'd0;
    localparam logic [0:0] CFG_LAST_LINE  = 1'd1;
    localparam logic [7:0] FIRST_LINE_RST = 8'd161;
    localparam logic [7:0] LAST_LINE_RST  = 8'd225;

    // Special register indexes and bits
    localparam logic [6:0]  IDX_DISPCNT       = 7'd0;
    localparam logic [6:0]  IDX_DISPSTAT      = 7'd2;
    localparam logic [6:0]  IDX_VCOUNT        = 7'd3;
    localparam int          FORCED_BLANK_POS  = 7;
    localparam logic [15:0] DISPSTAT_IRQ_BITS = 16'h0018;

endpackage

// File: hw/rtl/shadow_register_deferred_commit.sv
`timescale 1ns / 1ps

// Double-buffered display register file. Shadow and live copies sit in two
// RAMs with a registered read; a write updates the shadow copy and
// either commits to the live copy at once (blanking window, forced blank,
// immediate mode) or, with room in the queue, queues it once for a later
// flush. For a write, read or acknowledge item the accept edge launches the
// RAM read, and the ST_EXEC edge does modify and write-back and loads the
// result beat, which raises m_valid. A flush of a non-empty queue steps
// through ST_FL_ORD and ST_FL_COMMIT per queued register, the queue RAM read
// feeding the shadow/live read; an empty flush is acknowledged like any other
// item. While m_ready holds off a finished result, the write-back step stalls.
// Ready drops while an item is in work; one finished result can wait in the
// output register while the next item is accepted.
module shadow_register_deferred_commit #(
    parameter int REG_COUNT = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  srdc_pkg::in_t                       s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output srdc_pkg::out_t                      m_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam int CNT_W = $clog2(REG_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(REG_COUNT);
    localparam logic [7:0]       IDX_LIMIT = 8'(REG_COUNT);
    localparam logic [IDX_W-1:0] I_DISPCNT  = IDX_W'(srdc_pkg::IDX_DISPCNT);
    localparam logic [IDX_W-1:0] I_DISPSTAT = IDX_W'(srdc_pkg::IDX_DISPSTAT);
    localparam logic [IDX_W-1:0] I_VCOUNT   = IDX_W'(srdc_pkg::IDX_VCOUNT);

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_EXEC      = 2'd1;
    localparam logic [1:0] ST_FL_ORD    = 2'd2;
    localparam logic [1:0] ST_FL_COMMIT = 2'd3;

    logic [1:0]           state_reg;
    logic                 out_vld_reg;
    srdc_pkg::out_t       out_reg;
    srdc_pkg::in_t        item_reg;
    logic [IDX_W-1:0]     r_reg;
    logic [7:0]           first_line_reg;
    logic [7:0]           last_line_reg;
    logic [REG_COUNT-1:0] shadow_vld_reg;
    logic [REG_COUNT-1:0] live_vld_reg;
    logic [REG_COUNT-1:0] mark_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     ptr_next;
    logic                 forced_blank_reg;

    logic                 s_fire;
    logic                 out_free;
    logic [6:0]           s_idx7;
    logic [6:0]           item_idx7;
    logic [IDX_W-1:0]     item_idx;
    logic [6:0]           r_idx7;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     file_raddr;
    logic [IDX_W-1:0]     ord_rd;
    logic [15:0]          sh_rd;
    logic [15:0]          lv_rd;
    logic [15:0]          sh_old;
    logic [15:0]          lv_old;
    logic [15:0]          new_value;
    logic [15:0]          base_val;
    logic [15:0]          new_live;
    logic [15:0]          read_val;
    logic                 in_range;
    logic                 in_win;
    logic                 is_wr;
    logic                 is_rd;
    logic                 do_commit;
    logic                 do_queue;
    logic                 exec_fire;
    logic                 fl_fire;
    logic                 fl_last;
    logic                 sh_we;
    logic                 lv_we;
    logic [IDX_W-1:0]     lv_waddr;
    srdc_pkg::out_t       res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_payload = out_reg;
    assign out_free  = !out_vld_reg || m_ready;

    assign s_idx7    = s_payload.reg_offset[7:1];
    assign item_idx7 = item_reg.reg_offset[7:1];
    assign item_idx  = item_idx7[IDX_W-1:0];
    assign r_idx7    = 7'(r_reg);
    assign rd_idx    = (state_reg == ST_FL_COMMIT) ? r_reg : item_idx;

    // File read address: incoming beat, queued register, or held item
    always_comb begin
        unique case (state_reg)
            ST_IDLE:      file_raddr = s_idx7[IDX_W-1:0];
            ST_FL_ORD:    file_raddr = ord_rd;
            ST_FL_COMMIT: file_raddr = r_reg;
            default:      file_raddr = item_idx;
        endcase
    end

    // Never-written entries read as zero
    assign sh_old = shadow_vld_reg[rd_idx] ? sh_rd : 16'd0;
    assign lv_old = live_vld_reg[rd_idx] ? lv_rd : 16'd0;

    // Decode of the held item
    assign in_range = ({1'b0, item_idx7} < IDX_LIMIT);
    assign in_win   = (item_reg.scanline >= first_line_reg)
                   && (item_reg.scanline <= last_line_reg);
    assign is_wr    = in_range && ((item_reg.mode == srdc_pkg::MODE_WRITE)
                   || (item_reg.mode == srdc_pkg::MODE_IMM)
                   || (item_reg.mode == srdc_pkg::MODE_SET)
                   || (item_reg.mode == srdc_pkg::MODE_CLR));
    assign is_rd    = in_range && (item_reg.mode == srdc_pkg::MODE_READ);
    assign do_commit = is_wr && ((item_reg.mode == srdc_pkg::MODE_IMM)
                    || in_win || forced_blank_reg);
    assign do_queue  = is_wr && !do_commit && !mark_reg[item_idx]
                    && (count_reg < CNT_FULL);

    // Shadow modify
    always_comb begin
        unique case (item_reg.mode)
            srdc_pkg::MODE_SET: new_value = sh_old | item_reg.data_word;
            srdc_pkg::MODE_CLR: new_value = sh_old & ~item_reg.data_word;
            default:            new_value = item_reg.data_word;
        endcase
    end

    // Live commit value; DISPSTAT keeps its non-IRQ live bits and ORs in the new value
    assign base_val = (state_reg == ST_FL_COMMIT) ? sh_old : new_value;
    assign new_live = (rd_idx == I_DISPSTAT)
                    ? ((lv_old & ~srdc_pkg::DISPSTAT_IRQ_BITS) | base_val)
                    : base_val;

    // Read data source
    always_comb begin
        priority if (item_idx == I_DISPSTAT) begin
            read_val = lv_old;
        end else if (item_idx == I_VCOUNT) begin
            read_val = {8'd0, item_reg.scanline};
        end else begin
            read_val = sh_old;
        end
    end

    assign exec_fire = (state_reg == ST_EXEC) && out_free;
    assign fl_fire   = (state_reg == ST_FL_COMMIT) && out_free;
    assign fl_last   = (CNT_W'(ptr_reg + 1'b1) == count_reg);

    // Queue read pointer; the queue RAM is addressed by the next value
    always_comb begin
        ptr_next = ptr_reg;
        if (fl_fire) begin
            ptr_next = fl_last ? '0 : CNT_W'(ptr_reg + 1'b1);
        end
    end

    // Result beat
    always_comb begin
        if (state_reg == ST_FL_COMMIT) begin
            res.kind          = srdc_pkg::KIND_COMMIT;
            res.commit_offset = {r_idx7[5:0], 1'b0};
            res.word_value    = new_live;
            res.last          = fl_last;
        end else if (do_commit) begin
            res.kind          = srdc_pkg::KIND_COMMIT;
            res.commit_offset = {item_idx7[5:0], 1'b0};
            res.word_value    = new_live;
            res.last          = 1'b1;
        end else if (is_rd) begin
            res.kind          = srdc_pkg::KIND_READ;
            res.commit_offset = {item_idx7[5:0], 1'b0};
            res.word_value    = read_val;
            res.last          = 1'b1;
        end else begin
            res.kind          = srdc_pkg::KIND_ACK;
            res.commit_offset = 7'd0;
            res.word_value    = 16'd0;
            res.last          = 1'b1;
        end
    end

    assign sh_we    = exec_fire && is_wr;
    assign lv_we    = (exec_fire && do_commit) || fl_fire;
    assign lv_waddr = rd_idx;

    srdc_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_shadow (
        .aclk    (aclk),
        .wr_en   (sh_we),
        .wr_addr (item_idx),
        .wr_data (new_value),
        .rd_addr (file_raddr),
        .rd_data (sh_rd)
    );

    srdc_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_live (
        .aclk    (aclk),
        .wr_en   (lv_we),
        .wr_addr (lv_waddr),
        .wr_data (new_live),
        .rd_addr (file_raddr),
        .rd_data (lv_rd)
    );

    srdc_ram #(.WIDTH(IDX_W), .DEPTH(REG_COUNT)) u_order (
        .aclk    (aclk),
        .wr_en   (exec_fire && do_queue),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (item_idx),
        .rd_addr (ptr_next[IDX_W-1:0]),
        .rd_data (ord_rd)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_vld_reg      <= 1'b0;
            first_line_reg   <= srdc_pkg::FIRST_LINE_RST;
            last_line_reg    <= srdc_pkg::LAST_LINE_RST;
            shadow_vld_reg   <= '0;
            live_vld_reg     <= '0;
            mark_reg         <= '0;
            count_reg        <= '0;
            ptr_reg          <= '0;
            forced_blank_reg <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;

            // Configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    srdc_pkg::CFG_FIRST_LINE: first_line_reg <= cfg_data;
                    srdc_pkg::CFG_LAST_LINE:  last_line_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Output register
            if (exec_fire || fl_fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end

            if (sh_we) begin
                shadow_vld_reg[item_idx] <= 1'b1;
            end
            if (lv_we) begin
                live_vld_reg[lv_waddr] <= 1'b1;
                if (lv_waddr == I_DISPCNT) begin
                    forced_blank_reg <= new_live[srdc_pkg::FORCED_BLANK_POS];
                end
            end

            // Queue bookkeeping
            if (exec_fire && do_queue) begin
                mark_reg[item_idx] <= 1'b1;
                count_reg          <= CNT_W'(count_reg + 1'b1);
            end
            if (fl_fire) begin
                mark_reg[r_reg] <= 1'b0;
                if (fl_last) begin
                    count_reg <= '0;
                end
            end

            // Sequencer
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_payload.mode == srdc_pkg::MODE_FLUSH && count_reg != '0) begin
                            state_reg <= ST_FL_ORD;
                        end else begin
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC: begin
                    if (exec_fire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FL_ORD: begin
                    state_reg <= ST_FL_COMMIT;
                end
                ST_FL_COMMIT: begin
                    if (fl_fire) begin
                        state_reg <= fl_last ? ST_IDLE : ST_FL_ORD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_payload;
        end
        if (state_reg == ST_FL_ORD) begin
            r_reg <= ord_rd;
        end
        if (exec_fire || fl_fire) begin
            out_reg <= res;
        end
    end

endmodule

// File: hw/rtl/srdc_ram.sv
`timescale 1ns / 1ps

module srdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
